[design/glr_pkg.sv]
`timescale 1ns / 1ps

package glr_pkg;

  localparam int ORIENT_W   = 27;
  localparam int VALUE_W    = 32;
  localparam int WIDTH_W    = 31;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_MAG_W  = 34;
  localparam int MUL_OP_W   = MUL_MAG_W + 1;
  localparam int SAT_IN_W   = 80;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [WIDTH_W-1:0]        RST_ALPHA    = 31'd16777216;
  localparam logic [WIDTH_W-1:0]        RST_BETA     = 31'd8388608;
  localparam logic signed [VALUE_W-1:0] RST_SCALE_A  = 32'sd16777216;
  localparam logic signed [VALUE_W-1:0] RST_SCALE_B  = 32'sd16777216;
  localparam logic [ORIENT_W-1:0]       RST_BRANDON  = 27'd4392265;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ALPHA    = 3'd0,
    REG_BETA     = 3'd1,
    REG_SCALE_A  = 3'd2,
    REG_SCALE_B  = 3'd3,
    REG_BRANDON  = 3'd4,
    REG_MOBILITY = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [ORIENT_W-1:0]        grain_orientation;
    logic signed [VALUE_W-1:0]  conv_value_one;
    logic signed [VALUE_W-1:0]  conv_value_two;
    logic                       last_grain;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  levelset_value;
    logic                       last_result;
  } out_item_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]         alpha_width;
    logic [WIDTH_W-1:0]         beta_width;
    logic signed [VALUE_W-1:0]  scale_a;
    logic signed [VALUE_W-1:0]  scale_b;
    logic [ORIENT_W-1:0]        brandon_angle;
    logic                       mobility_mode;
  } cfg_regs_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(VALUE_MAX);
    lo = SAT_IN_W'(VALUE_MIN);
    if (v > hi) begin
      return VALUE_MAX;
    end else if (v < lo) begin
      return VALUE_MIN;
    end
    return v[VALUE_W-1:0];
  endfunction

endpackage

[design/glr_ram.sv]
`timescale 1ns / 1ps

module glr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

[design/glr_mul.sv]
`timescale 1ns / 1ps

module glr_mul import glr_pkg::*; #(
  parameter int FRAC_BITS = 24,
  localparam int PROD_W = 2 * MUL_MAG_W - FRAC_BITS + 1
) (
  input  logic                       clk,
  input  logic signed [MUL_OP_W-1:0] op_a,
  input  logic signed [MUL_OP_W-1:0] op_b,
  output logic signed [PROD_W-1:0]   prod_r
);

  logic [MUL_MAG_W-1:0]   mag_a;
  logic [MUL_MAG_W-1:0]   mag_b;
  logic [2*MUL_MAG_W-1:0] full;
  logic [PROD_W-2:0]      mag_p;
  logic                   neg;
  logic signed [PROD_W-1:0] prod_nxt;

  // Sign and magnitude, product truncated toward zero.
  always_comb begin
    neg      = op_a[MUL_OP_W-1] ^ op_b[MUL_OP_W-1];
    mag_a    = op_a[MUL_OP_W-1] ? MUL_MAG_W'(-op_a) : MUL_MAG_W'(op_a);
    mag_b    = op_b[MUL_OP_W-1] ? MUL_MAG_W'(-op_b) : MUL_MAG_W'(op_b);
    full     = mag_a * mag_b;
    mag_p    = full[2*MUL_MAG_W-1:FRAC_BITS];
    prod_nxt = neg ? -signed'({1'b0, mag_p}) : signed'({1'b0, mag_p});
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[design/glr_engine.sv]
`timescale 1ns / 1ps

module glr_engine import glr_pkg::*; #(
  parameter int MAX_GRAINS = 64,
  parameter int FRAC_BITS  = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  cfg_regs_t cfg,
  output result_t   res,
  input  logic      res_free
);

  localparam int AW     = $clog2(MAX_GRAINS);
  localparam int CW     = $clog2(MAX_GRAINS + 1);
  localparam int ECW    = $clog2(FRAC_BITS + 1);
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int OPW    = MUL_OP_W;
  localparam int PROD_W = 2 * MUL_MAG_W - FRAC_BITS + 1;
  localparam int SUM_W  = PROD_W + 7;
  localparam int GS_W   = ORIENT_W + 2 * VALUE_W;

  localparam logic [CW-1:0]        MAX_C   = CW'(MAX_GRAINS);
  localparam logic signed [OPW-1:0] ONE_Q  = OPW'(64'd1 << FRAC_BITS);
  localparam logic [31:0]          TWO_PI_Q =
      32'((64'h6487ED511 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic signed [OPW-1:0] LN2_Q  =
      OPW'((64'hB17217F8 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  typedef enum logic [4:0] {
    S_IDLE, S_K_RD, S_K_LD, S_L_CHK, S_L_RD, S_L_LD, S_DIFF, S_MSEL, S_DIV, S_NORM,
    S_SQ_ISS, S_SQ_TAKE, S_LN_ISS, S_LN_TAKE, S_ST_ISS, S_ST_TAKE, S_COEF, S_PA_ISS,
    S_TB_SET, S_A_ISS, S_B_ISS, S_C1_ISS, S_C2_ISS, S_ACC, S_PHI_WR, S_OUT_RD, S_OUT_PUT
  } state_t;

  state_t state_r;

  logic [CW-1:0]              count_r, n_r, k_r, l_r;
  logic [ORIENT_W-1:0]        ok_r, ol_r, d_r, rem_r;
  logic signed [VALUE_W-1:0]  c1_r, c2_r, a_r, b_r, min1_r, min2_r;
  logic [AW-1:0]              idx_r;
  logic [Q_W-1:0]             q_r, x_r;
  logic [ECW-1:0]             e_r, it_r;
  logic [FRAC_BITS-1:0]       frac_r;
  logic signed [OPW-1:0]      onemln_r, st_r, ta_r, tb_r;
  logic signed [SUM_W-1:0]    sum_r;

  logic                       gs_we, phi_we;
  logic [AW-1:0]              raddr;
  logic [GS_W-1:0]            gs_wdata, gs_rdata;
  logic [VALUE_W-1:0]         phi_rdata;
  logic [ORIENT_W-1:0]        rd_orient;
  logic signed [VALUE_W-1:0]  rd_c1, rd_c2, phi_val, rd_phi, mn;
  logic signed [OPW-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic [OPW-1:0]             l2mag;
  logic [31:0]                d32, w_val;
  logic [ORIENT_W-1:0]        m_val;
  logic [ORIENT_W:0]          div_t;
  logic                       div_ge;
  logic [Q_W:0]               sq;
  logic                       full;

  glr_ram #(.WIDTH(GS_W), .DEPTH(MAX_GRAINS)) u_grain_store (
    .clk(clk), .we(gs_we), .waddr(count_r[AW-1:0]), .wdata(gs_wdata),
    .raddr(raddr), .rdata_r(gs_rdata)
  );

  glr_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_GRAINS)) u_phi_store (
    .clk(clk), .we(phi_we), .waddr(k_r[AW-1:0]), .wdata(phi_val),
    .raddr(raddr), .rdata_r(phi_rdata)
  );

  glr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .op_a(mul_a), .op_b(mul_b), .prod_r(prod_r)
  );

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    full      = (count_r >= MAX_C);
    gs_we     = in_ready && in_valid && !full;
    gs_wdata  = {in_data.grain_orientation, in_data.conv_value_one, in_data.conv_value_two};
    phi_we    = (state_r == S_PHI_WR);
    raddr     = (state_r == S_L_RD) ? l_r[AW-1:0] : k_r[AW-1:0];
    rd_orient = gs_rdata[GS_W-1:2*VALUE_W];
    rd_c1     = gs_rdata[2*VALUE_W-1:VALUE_W];
    rd_c2     = gs_rdata[VALUE_W-1:0];
    rd_phi    = phi_rdata;
    phi_val   = sat32(SAT_IN_W'(sum_r));
    l2mag     = (OPW'(e_r) << FRAC_BITS) - OPW'(frac_r);
    d32       = 32'(d_r);
    w_val     = (d32 >= TWO_PI_Q) ? 32'd0 : TWO_PI_Q - d32;
    m_val     = (d32 < w_val) ? d_r : w_val[ORIENT_W-1:0];
    div_t     = {rem_r, 1'b0};
    div_ge    = (div_t >= {1'b0, cfg.brandon_angle});
    sq        = prod_r[Q_W:0];
    mn        = (k_r[AW-1:0] == idx_r) ? min2_r : min1_r;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ_ISS: begin
        mul_a = OPW'(x_r);
        mul_b = OPW'(x_r);
      end
      S_LN_ISS: begin
        mul_a = l2mag;
        mul_b = LN2_Q;
      end
      S_ST_ISS: begin
        mul_a = OPW'(q_r);
        mul_b = onemln_r;
      end
      S_COEF: begin
        mul_a = OPW'(cfg.beta_width);
        mul_b = st_r;
      end
      S_PA_ISS: begin
        mul_a = OPW'(cfg.alpha_width);
        mul_b = st_r;
      end
      S_A_ISS: begin
        mul_a = OPW'(cfg.scale_a);
        mul_b = ta_r;
      end
      S_B_ISS: begin
        mul_a = OPW'(cfg.scale_b);
        mul_b = tb_r;
      end
      S_C1_ISS: begin
        mul_a = OPW'(a_r);
        mul_b = OPW'(c1_r);
      end
      S_C2_ISS: begin
        mul_a = OPW'(b_r);
        mul_b = OPW'(c2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    res.valid                     = (state_r == S_OUT_PUT);
    res.item.last_result          = (k_r + CW'(1) == n_r);
    res.item.levelset_value       = (n_r == CW'(1)) ? rd_c1 :
                                    sat32(SAT_IN_W'(mn) - SAT_IN_W'(rd_phi));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (!full) begin
              count_r <= count_r + CW'(1);
            end
            if (in_data.last_grain) begin
              count_r <= '0;
              n_r     <= full ? count_r : count_r + CW'(1);
              k_r     <= '0;
              state_r <= (count_r == '0) ? S_OUT_RD : S_K_RD;
            end
          end
        end
        S_K_RD: state_r <= S_K_LD;
        S_K_LD: begin
          ok_r    <= rd_orient;
          l_r     <= '0;
          sum_r   <= '0;
          state_r <= S_L_CHK;
        end
        S_L_CHK: begin
          if (l_r == n_r) begin
            state_r <= S_PHI_WR;
          end else if (l_r == k_r) begin
            l_r <= l_r + CW'(1);
          end else begin
            state_r <= S_L_RD;
          end
        end
        S_L_RD: state_r <= S_L_LD;
        S_L_LD: begin
          ol_r    <= rd_orient;
          c1_r    <= rd_c1;
          c2_r    <= rd_c2;
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          d_r     <= (ok_r > ol_r) ? ok_r - ol_r : ol_r - ok_r;
          state_r <= S_MSEL;
        end
        S_MSEL: begin
          if (m_val == '0) begin
            st_r    <= '0;
            state_r <= S_COEF;
          end else if (m_val > cfg.brandon_angle) begin
            st_r    <= ONE_Q;
            state_r <= S_COEF;
          end else begin
            q_r     <= (m_val == cfg.brandon_angle) ? Q_W'(1) : '0;
            rem_r   <= (m_val == cfg.brandon_angle) ? '0 : m_val;
            it_r    <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= div_ge ? ORIENT_W'(div_t - {1'b0, cfg.brandon_angle}) : div_t[ORIENT_W-1:0];
          q_r   <= {q_r[Q_W-2:0], div_ge};
          it_r  <= it_r + ECW'(1);
          if (it_r == ECW'(FRAC_BITS - 1)) begin
            x_r     <= {q_r[Q_W-2:0], div_ge};
            e_r     <= '0;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (x_r[FRAC_BITS] || e_r == ECW'(FRAC_BITS)) begin
            it_r    <= '0;
            frac_r  <= '0;
            state_r <= S_SQ_ISS;
          end else begin
            x_r <= {x_r[Q_W-2:0], 1'b0};
            e_r <= e_r + ECW'(1);
          end
        end
        S_SQ_ISS: state_r <= S_SQ_TAKE;
        S_SQ_TAKE: begin
          if (sq[Q_W]) begin
            x_r    <= sq[Q_W:1];
            frac_r <= {frac_r[FRAC_BITS-2:0], 1'b1};
          end else begin
            x_r    <= sq[Q_W-1:0];
            frac_r <= {frac_r[FRAC_BITS-2:0], 1'b0};
          end
          it_r    <= it_r + ECW'(1);
          state_r <= (it_r == ECW'(FRAC_BITS - 1)) ? S_LN_ISS : S_SQ_ISS;
        end
        S_LN_ISS: state_r <= S_LN_TAKE;
        S_LN_TAKE: begin
          onemln_r <= ONE_Q + prod_r[OPW-1:0];
          state_r  <= S_ST_ISS;
        end
        S_ST_ISS: state_r <= S_ST_TAKE;
        S_ST_TAKE: begin
          st_r    <= prod_r[OPW-1:0];
          state_r <= S_COEF;
        end
        S_COEF: begin
          if (cfg.mobility_mode) begin
            state_r <= S_PA_ISS;
          end else begin
            ta_r    <= st_r - OPW'(cfg.beta_width);
            tb_r    <= OPW'(cfg.alpha_width) - st_r;
            state_r <= S_A_ISS;
          end
        end
        S_PA_ISS: begin
          ta_r    <= st_r - prod_r[OPW-1:0];
          state_r <= S_TB_SET;
        end
        S_TB_SET: begin
          tb_r    <= prod_r[OPW-1:0] - st_r;
          state_r <= S_A_ISS;
        end
        S_A_ISS: state_r <= S_B_ISS;
        S_B_ISS: begin
          a_r     <= sat32(SAT_IN_W'(prod_r));
          state_r <= S_C1_ISS;
        end
        S_C1_ISS: begin
          b_r     <= sat32(SAT_IN_W'(prod_r));
          state_r <= S_C2_ISS;
        end
        S_C2_ISS: begin
          sum_r   <= sum_r + SUM_W'(prod_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_r + SUM_W'(prod_r);
          l_r     <= l_r + CW'(1);
          state_r <= S_L_CHK;
        end
        S_PHI_WR: begin
          if (k_r == '0) begin
            min1_r <= phi_val;
            min2_r <= VALUE_MAX;
            idx_r  <= '0;
          end else if (phi_val < min1_r) begin
            min2_r <= min1_r;
            min1_r <= phi_val;
            idx_r  <= k_r[AW-1:0];
          end else if (phi_val < min2_r) begin
            min2_r <= phi_val;
          end
          if (k_r + CW'(1) == n_r) begin
            k_r     <= '0;
            state_r <= S_OUT_RD;
          end else begin
            k_r     <= k_r + CW'(1);
            state_r <= S_K_RD;
          end
        end
        S_OUT_RD: state_r <= S_OUT_PUT;
        S_OUT_PUT: begin
          if (res_free) begin
            if (k_r + CW'(1) == n_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + CW'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/grain_levelset_redistribution.sv]
`timescale 1ns / 1ps

// Grain level-set redistribution for one pixel at a time.
// Input requests carry one nearby grain each (orientation, two convolution
// values, last flag); the grains of a pixel are loaded back to back, one per
// cycle, while in_ready is high. The request with last_grain set closes the
// pixel and in_ready falls until every result of that pixel has been handed
// to the output register.
// With n grains the sequencer visits every ordered pair, all multiplications going
// through one shared multiplier and a one-bit-a-cycle divider. A pair inside
// the Brandon angle runs the divider, the normalising shift and FRAC_BITS
// squaring rounds; mobility_mode adds the width products for either kind of
// pair. A pixel with one grain skips the pairs. Results leave in load order
// through a single output register; when the receiver stalls the sequencer
// waits on the current result. Configuration writes are taken at any edge
// with cfg_we, and are meant for an idle block. Reset returns the sequencer
// to idle, empties the grain count, clears the output valid flag and
// restores the register defaults.
module grain_levelset_redistribution import glr_pkg::*; #(
  parameter int MAX_GRAINS = 64,
  parameter int FRAC_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_regs_t cfg_r;
  result_t   res;
  logic      res_free;
  logic      out_valid_r;
  out_item_t out_data_r;

  glr_engine #(.MAX_GRAINS(MAX_GRAINS), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .cfg(cfg_r), .res(res), .res_free(res_free)
  );

  assign res_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_width   <= RST_ALPHA;
      cfg_r.beta_width    <= RST_BETA;
      cfg_r.scale_a       <= RST_SCALE_A;
      cfg_r.scale_b       <= RST_SCALE_B;
      cfg_r.brandon_angle <= RST_BRANDON;
      cfg_r.mobility_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ALPHA:    cfg_r.alpha_width   <= cfg_wdata[WIDTH_W-1:0];
        REG_BETA:     cfg_r.beta_width    <= cfg_wdata[WIDTH_W-1:0];
        REG_SCALE_A:  cfg_r.scale_a       <= cfg_wdata;
        REG_SCALE_B:  cfg_r.scale_b       <= cfg_wdata;
        REG_BRANDON:  cfg_r.brandon_angle <= cfg_wdata[ORIENT_W-1:0];
        REG_MOBILITY: cfg_r.mobility_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_free) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res.item;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

[design/glr_checker.sv]
`timescale 1ns / 1ps

module glr_checker import glr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_grain |=> !in_ready)
    else $error("input still open after the last grain of a pixel");

  a_load_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.last_grain |=> in_ready)
    else $error("input closed in the middle of a pixel");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result produced while loading grains");

endmodule

bind grain_levelset_redistribution glr_checker u_glr_checker (.*);
